// File: hw/rtl/pwdq_pkg.sv
// ----------------------------------------------------------------------------
// Position-weighted DCT quantizer package
// Widths, constants, the luminance table and the item carrier type that the
// quantizer pipeline shares.
// ----------------------------------------------------------------------------
package pwdq_pkg;

   // Field widths.
   localparam int COEF_W     = 16;
   localparam int IDX_W      = 6;
   localparam int POS_W      = 8;
   localparam int QUAL_W     = 7;
   localparam int STEP_W     = 14;
   localparam int WGT_W      = 10;
   localparam int LQ_W       = 16;
   localparam int S8_W       = 22;
   localparam int D1_REM_W   = 17;
   localparam int N_W        = 19;
   localparam int D2_NUM_W   = 17;
   localparam int D2_QUO_W   = 12;
   localparam int D2_REM_W   = 18;

   // Register map.
   localparam logic REG_BASE_QUALITY = 1'b0;

   // Quality limits and reset value.
   localparam logic [QUAL_W-1:0] QUAL_RESET = 7'd100;
   localparam logic [QUAL_W-1:0] QUAL_MIN   = 7'd1;
   localparam logic [QUAL_W-1:0] QUAL_MAX   = 7'd100;

   // Scale factor constants: local quality 50 with 9 fractional bits, the
   // linear-branch base 200 with 8 fractional bits, and twice 5000 * 2^17.
   localparam logic [LQ_W-1:0] LQ_KNEE        = 16'd25600;
   localparam logic [LQ_W-1:0] S8_LINEAR_BASE = 16'd51200;
   localparam logic [30:0]     SCALE_NUM2     = 31'd1310720000;

   // Step rounding bias (100 with 8 fractional bits) and the
   // reciprocal of 25 with 20 fractional bits, rounded down.
   localparam logic [29:0] STEP_BIAS = 30'd25600;
   localparam logic [15:0] RECIP_25  = 16'd41943;
   localparam logic [4:0]  DIV_25    = 5'd25;

   // Luminance quantization table, row-major: the standard one but for entry 13 (28, not 58).
   localparam logic [6:0] LUM_TABLE [64] = '{
      7'd16, 7'd11, 7'd10, 7'd16, 7'd24,  7'd40,  7'd51,  7'd61,
      7'd12, 7'd12, 7'd14, 7'd19, 7'd26,  7'd28,  7'd60,  7'd55,
      7'd14, 7'd13, 7'd16, 7'd24, 7'd40,  7'd57,  7'd69,  7'd56,
      7'd14, 7'd17, 7'd22, 7'd29, 7'd51,  7'd87,  7'd80,  7'd62,
      7'd18, 7'd22, 7'd37, 7'd56, 7'd68,  7'd109, 7'd103, 7'd77,
      7'd24, 7'd35, 7'd55, 7'd64, 7'd81,  7'd104, 7'd113, 7'd92,
      7'd49, 7'd64, 7'd78, 7'd87, 7'd103, 7'd121, 7'd120, 7'd101,
      7'd72, 7'd92, 7'd95, 7'd98, 7'd112, 7'd100, 7'd103, 7'd99
   };

   // Per-item values that ride along the early pipeline.
   typedef struct packed {
      logic              neg;
      logic [COEF_W-1:0] mag;
      logic [6:0]        qent;
   } carry_type;

   // Distance of a position to the nearer image edge, 0..128.
   function automatic logic [POS_W-1:0] edge_dist(input logic [POS_W-1:0] p);
      logic [POS_W:0] other;
      other = 9'd256 - {1'b0, p};
      edge_dist = p[POS_W-1] ? other[POS_W-1:0] : p;
   endfunction

endpackage

// File: hw/rtl/position_weighted_dct_quantizer_unit.sv
// ----------------------------------------------------------------------------
// Position-weighted DCT quantizer
// Quantizes one DCT coefficient per request with a step derived from the
// JPEG quality scaling rule, where the quality depends on the block position.
// ----------------------------------------------------------------------------
// The block takes one coefficient request in every clock cycle unless the
// result side stalls; most of its pipeline stages belong to two restoring
// dividers that resolve one quotient bit per stage (22 stages for the quality
// scale factor, 12 for rounding the coefficient to the step). The whole
// pipeline advances together, so a stall on the result side holds every
// stage and lowers req_tready. base_quality should be written only while no
// request is in flight; values of 0 act as 1 and values 101 to 127 act as 100.
module position_weighted_dct_quantizer_unit (
   input  logic        clock,
   input  logic        reset,
   // Request: [15:0] coefficient, [21:16] coef_index, [29:22] pos_x,
   // [37:30] pos_y, [39:38] zero.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,
   // Result: [15:0] quantized_value, [29:16] step_size, [31:30] zero.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   // Result flags: [0] saturated.
   output logic [0:0]  rsp_tuser,
   // Register port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import pwdq_pkg::*;

   localparam int D1_STAGES = S8_W;
   localparam int D2_STAGES = D2_QUO_W;

   logic adv;

   // Configuration register.
   logic [QUAL_W-1:0] qual_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_BASE_QUALITY) ?
                       {{(32-QUAL_W){1'b0}}, qual_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         qual_ff <= QUAL_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[2] == REG_BASE_QUALITY)) begin
         qual_ff <= csr_pwdata[QUAL_W-1:0];
      end
   end

   // The pipeline moves when the output register is free or being emptied.
   logic rsp_vld_ff;
   assign adv        = !rsp_vld_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_vld_ff;

   // Stage A: decode the request, take magnitude, edge weight, table entry and clamped quality.
   logic [COEF_W-1:0] coef;
   logic [POS_W-1:0]  mx, my;
   carry_type         a_car_in;
   logic [WGT_W-1:0]  a_w_in;
   logic [QUAL_W-1:0] a_q_in;
   logic              a_vld_ff;
   carry_type         a_car_ff;
   logic [WGT_W-1:0]  a_w_ff;
   logic [QUAL_W-1:0] a_q_ff;

   always_comb begin
      coef          = req_tdata[15:0];
      mx            = edge_dist(req_tdata[29:22]);
      my            = edge_dist(req_tdata[37:30]);
      a_car_in.neg  = coef[COEF_W-1];
      a_car_in.mag  = coef[COEF_W-1] ? (16'd0 - coef) : coef;
      a_car_in.qent = LUM_TABLE[req_tdata[21:16]];
      a_w_in        = 10'd256 + WGT_W'(mx) + WGT_W'(my);
      if (qual_ff < QUAL_MIN) begin
         a_q_in = QUAL_MIN;
      end else if (qual_ff > QUAL_MAX) begin
         a_q_in = QUAL_MAX;
      end else begin
         a_q_in = qual_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_car_ff <= a_car_in;
         a_w_ff   <= a_w_in;
         a_q_ff   <= a_q_in;
      end
   end

   // Stage B: local quality with 9 fractional bits, then load divider one.
   logic [LQ_W-1:0]     b_lq_in;
   logic [30:0]         b_num_in;
   logic [D1_REM_W-1:0] d1_rem_ff [0:D1_STAGES];
   logic [S8_W-1:0]     d1_low_ff [0:D1_STAGES];
   logic [LQ_W-1:0]     d1_lq_ff  [0:D1_STAGES];
   carry_type           d1_car_ff [0:D1_STAGES];
   logic                d1_vld_ff [0:D1_STAGES];

   always_comb begin
      b_lq_in  = LQ_W'(a_q_ff) * LQ_W'(a_w_ff);
      b_num_in = SCALE_NUM2 + 31'(b_lq_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         d1_vld_ff[0] <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d1_rem_ff[0] <= D1_REM_W'(b_num_in[30:S8_W]);
         d1_low_ff[0] <= b_num_in[S8_W-1:0];
         d1_lq_ff[0]  <= b_lq_in;
         d1_car_ff[0] <= a_car_ff;
      end
   end

   // Divider one: one quotient bit of the scale factor per stage.
   for (genvar k = 0; k < D1_STAGES; k++) begin : g_div1
      logic [D1_REM_W:0]   shifted;
      logic [D1_REM_W:0]   dvs;
      logic                ge;
      logic [D1_REM_W-1:0] rem_in;
      logic [S8_W-1:0]     low_in;

      always_comb begin
         shifted = {d1_rem_ff[k], d1_low_ff[k][S8_W-1]};
         dvs     = {1'b0, d1_lq_ff[k], 1'b0};
         ge      = (shifted >= dvs);
         rem_in  = ge ? D1_REM_W'(shifted - dvs) : shifted[D1_REM_W-1:0];
         low_in  = {d1_low_ff[k][S8_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            d1_vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            d1_vld_ff[k+1] <= d1_vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            d1_rem_ff[k+1] <= rem_in;
            d1_low_ff[k+1] <= low_in;
            d1_lq_ff[k+1]  <= d1_lq_ff[k];
            d1_car_ff[k+1] <= d1_car_ff[k];
         end
      end
   end

   // Stage E: pick the reciprocal or the linear scale factor.
   logic [S8_W-1:0] e_s8_in;
   logic            e_vld_ff;
   logic [S8_W-1:0] e_s8_ff;
   carry_type       e_car_ff;

   assign e_s8_in = (d1_lq_ff[D1_STAGES] >= LQ_KNEE) ?
                    S8_W'(S8_LINEAR_BASE - d1_lq_ff[D1_STAGES]) :
                    d1_low_ff[D1_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else if (adv) begin
         e_vld_ff <= d1_vld_ff[D1_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_s8_ff  <= e_s8_in;
         e_car_ff <= d1_car_ff[D1_STAGES];
      end
   end

   // Stage F: scaled table entry plus bias, divided by 1024.
   logic [29:0]    f_prod;
   logic           f_vld_ff;
   logic [N_W-1:0] f_n_ff;
   carry_type      f_car_ff;

   assign f_prod = 30'(e_s8_ff) * 30'(e_car_ff.qent) + STEP_BIAS;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else if (adv) begin
         f_vld_ff <= e_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_n_ff   <= f_prod[N_W+9:10];
         f_car_ff <= e_car_ff;
      end
   end

   // Stage G: estimate of the quotient by 25, low by at most one.
   logic [34:0]       g_prod;
   logic              g_vld_ff;
   logic [N_W-1:0]    g_n_ff;
   logic [STEP_W-1:0] g_q0_ff;
   carry_type         g_car_ff;

   assign g_prod = 35'(f_n_ff) * 35'(RECIP_25);

   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
      end else if (adv) begin
         g_vld_ff <= f_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g_n_ff   <= f_n_ff;
         g_q0_ff  <= g_prod[STEP_W+19:20];
         g_car_ff <= f_car_ff;
      end
   end

   // Stage H: correct the estimate and keep the step at least one.
   logic [N_W-1:0]    h_rem;
   logic [STEP_W-1:0] h_step_raw;
   logic [STEP_W-1:0] h_step_in;
   logic              h_vld_ff;
   logic [STEP_W-1:0] h_step_ff;
   carry_type         h_car_ff;

   always_comb begin
      h_rem      = g_n_ff - N_W'(g_q0_ff) * N_W'(DIV_25);
      h_step_raw = (h_rem >= N_W'(DIV_25)) ? (g_q0_ff + 14'd1) : g_q0_ff;
      h_step_in  = (h_step_raw == '0) ? 14'd1 : h_step_raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_vld_ff <= 1'b0;
      end else if (adv) begin
         h_vld_ff <= g_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         h_step_ff <= h_step_in;
         h_car_ff  <= g_car_ff;
      end
   end

   // Divider two: magnitude plus eight steps, divided by sixteen steps over twelve stages.
   logic [D2_NUM_W-1:0] d2_num_in;
   logic [D2_REM_W-1:0] d2_rem_ff  [0:D2_STAGES];
   logic [D2_QUO_W-1:0] d2_low_ff  [0:D2_STAGES];
   logic [D2_NUM_W-1:0] d2_num_ff  [0:D2_STAGES];
   logic [STEP_W-1:0]   d2_step_ff [0:D2_STAGES];
   logic                d2_neg_ff  [0:D2_STAGES];
   logic                d2_vld_ff  [0:D2_STAGES];

   assign d2_num_in = D2_NUM_W'(h_car_ff.mag) + {h_step_ff, 3'b000};

   always_ff @(posedge clock) begin
      if (reset) begin
         d2_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         d2_vld_ff[0] <= h_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d2_rem_ff[0]  <= D2_REM_W'(d2_num_in[D2_NUM_W-1:D2_QUO_W]);
         d2_low_ff[0]  <= d2_num_in[D2_QUO_W-1:0];
         d2_num_ff[0]  <= d2_num_in;
         d2_step_ff[0] <= h_step_ff;
         d2_neg_ff[0]  <= h_car_ff.neg;
      end
   end

   for (genvar k = 0; k < D2_STAGES; k++) begin : g_div2
      logic [D2_REM_W:0]   shifted;
      logic [D2_REM_W:0]   dvs;
      logic                ge;
      logic [D2_REM_W-1:0] rem_in;
      logic [D2_QUO_W-1:0] low_in;

      always_comb begin
         shifted = {d2_rem_ff[k], d2_low_ff[k][D2_QUO_W-1]};
         dvs     = {1'b0, d2_step_ff[k], 4'b0000};
         ge      = (shifted >= dvs);
         rem_in  = ge ? D2_REM_W'(shifted - dvs) : shifted[D2_REM_W-1:0];
         low_in  = {d2_low_ff[k][D2_QUO_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            d2_vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            d2_vld_ff[k+1] <= d2_vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            d2_rem_ff[k+1]  <= rem_in;
            d2_low_ff[k+1]  <= low_in;
            d2_num_ff[k+1]  <= d2_num_ff[k];
            d2_step_ff[k+1] <= d2_step_ff[k];
            d2_neg_ff[k+1]  <= d2_neg_ff[k];
         end
      end
   end

   // Stage M: the step multiple is the dividend less the remainder.
   logic [D2_NUM_W-1:0] m_mag_in;
   logic                m_vld_ff;
   logic [D2_NUM_W-1:0] m_mag_ff;
   logic [STEP_W-1:0]   m_step_ff;
   logic                m_neg_ff;

   assign m_mag_in = d2_num_ff[D2_STAGES] - D2_NUM_W'(d2_rem_ff[D2_STAGES]);

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else if (adv) begin
         m_vld_ff <= d2_vld_ff[D2_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_mag_ff  <= m_mag_in;
         m_step_ff <= d2_step_ff[D2_STAGES];
         m_neg_ff  <= d2_neg_ff[D2_STAGES];
      end
   end

   // Output register: restore the sign and saturate to 16 bits.
   logic [COEF_W-1:0] o_val_in;
   logic              o_sat_in;
   logic [COEF_W-1:0] o_val_ff;
   logic [STEP_W-1:0] o_step_ff;
   logic              o_sat_ff;

   always_comb begin
      if (m_neg_ff) begin
         o_sat_in = (m_mag_ff > 17'd32768);
         o_val_in = o_sat_in ? 16'h8000 : (16'd0 - m_mag_ff[COEF_W-1:0]);
      end else begin
         o_sat_in = (m_mag_ff > 17'd32767);
         o_val_in = o_sat_in ? 16'h7fff : m_mag_ff[COEF_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= m_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         o_val_ff  <= o_val_in;
         o_step_ff <= m_step_ff;
         o_sat_ff  <= o_sat_in;
      end
   end

   assign rsp_tdata = {2'b00, o_step_ff, o_val_ff};
   assign rsp_tuser = o_sat_ff;

endmodule

// File: test/position_weighted_dct_quantizer_unit_tb.sv
// ----------------------------------------------------------------------------
// Position-weighted DCT quantizer testbench
// Sends coefficient requests under several quality settings and checks each
// result against its own model of the step and the rounding.
// ----------------------------------------------------------------------------
// The run starts with directed requests: field extremes, exact rounding
// halves, saturation, the centre and the edges of the image, and quality
// values that must be clamped. Random requests follow, first with the sender
// or the receiver idling often, then with neither idling. During the random
// part the receiver holds off for a long stretch once, and the sender once
// waits until every result has come back.
module position_weighted_dct_quantizer_unit_tb;
   import pwdq_pkg::*;

   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 5;
   localparam int LATENCY      = 43;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 300;
   localparam logic [2:0] ADDR_QUALITY = 3'd0;
   localparam logic [2:0] ADDR_UNUSED  = 3'd4;

   // Scoreboard: works out the step and the snapped coefficient of each
   // accepted request and compares results in order.
   class quantizer_scoreboard;
      typedef struct {
         logic [15:0] value;
         logic [13:0] step;
         logic        sat;
      } snapped_type;

      snapped_type pending[$];
      int unsigned quality = 100;
      int          errors  = 0;
      int          checked = 0;
      int          saturations = 0;

      function automatic longint unsigned edge_gap(input longint unsigned p);
         return (p < 256 - p) ? p : 256 - p;
      endfunction

      function automatic longint unsigned local_step(input logic [5:0] idx,
                                                     input logic [7:0] px,
                                                     input logic [7:0] py);
         longint unsigned q;
         longint unsigned lq9;
         longint unsigned s8;
         longint unsigned step;
         q = quality;
         if (q < 1) q = 1;
         if (q > 100) q = 100;
         lq9 = q * (256 + edge_gap(px) + edge_gap(py));
         if (lq9 < 25600)
            s8 = (2 * 655360000 + lq9) / (2 * lq9);
         else
            s8 = 51200 - lq9;
         step = (s8 * LUM_TABLE[idx] + 25600) / 25600;
         if (step < 1) step = 1;
         return step;
      endfunction

      function automatic void note_request(input logic [39:0] data);
         snapped_type     r;
         logic [15:0]     raw;
         longint unsigned step;
         longint unsigned mag;
         longint unsigned d;
         longint unsigned m;
         raw  = data[15:0];
         step = local_step(data[21:16], data[29:22], data[37:30]);
         mag  = raw[15] ? (65536 - raw) : raw;
         d    = 16 * step;
         m    = ((2 * mag + d) / (2 * d)) * d;
         r.sat = 1'b0;
         if (raw[15]) begin
            if (m > 32768) begin
               m = 32768;
               r.sat = 1'b1;
            end
            r.value = 16'(65536 - m);
         end else begin
            if (m > 32767) begin
               m = 32767;
               r.sat = 1'b1;
            end
            r.value = 16'(m);
         end
         r.step = 14'(step);
         pending.push_back(r);
      endfunction

      function automatic void check_result(input logic [31:0] data, input logic sat);
         snapped_type r;
         if (pending.size() == 0) begin
            $error("Result 0x%h arrived with no request outstanding", data);
            errors++;
            return;
         end
         r = pending.pop_front();
         checked++;
         if (r.sat) saturations++;
         if (data[15:0] !== r.value) begin
            $error("quantized_value: expected %0d, got %0d",
                   $signed(r.value), $signed(data[15:0]));
            errors++;
         end
         if (data[29:16] !== r.step) begin
            $error("step_size: expected %0d, got %0d", r.step, data[29:16]);
            errors++;
         end
         if (sat !== r.sat) begin
            $error("saturated: expected %0b, got %0b", r.sat, sat);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   quantizer_scoreboard quant_sb = new();
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  hold_request  = 1'b0;
   int  cycle_count   = 0;
   int  sent_count    = 0;

   position_weighted_dct_quantizer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #HALF_PERIOD clock = ~clock;

   // Cycle counter and run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Result side: check each accepted result, then choose the next tready.
   // A hold request keeps tready low for a long stretch.
   initial begin : result_side
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            quant_sb.check_result(rsp_tdata, rsp_tuser[0]);
         if (hold_request && hold_left == 0) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Offers one request and holds it until it is accepted.
   task automatic send_request(input logic [15:0] coef, input logic [5:0] idx,
                               input logic [7:0] px, input logic [7:0] py);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, py, px, idx, coef};
      do @(posedge clock); while (!req_tready);
      quant_sb.note_request({2'b00, py, px, idx, coef});
      sent_count++;
   endtask

   // Waits until every expected result has come, then lets the pipe drain.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (quant_sb.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   // Register write: a setup phase, then an access phase.
   task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == ADDR_QUALITY) quant_sb.quality = value & 32'h7F;
      @(posedge clock);
   endtask

   // Random request, biased towards small coefficients and exact halves.
   task automatic send_random();
      logic [15:0] coef;
      logic [5:0]  idx;
      logic [7:0]  px;
      logic [7:0]  py;
      int          sel;
      idx = $urandom();
      px  = $urandom();
      py  = $urandom();
      sel = $urandom_range(9);
      if (sel < 5)
         coef = $urandom();
      else if (sel < 8)
         coef = 16'($signed($urandom_range(4000)) - 2000);
      else
         coef = 16'((quant_sb.local_step(idx, px, py) * 8 *
                    (2 * $urandom_range(20) + 1)) * (sel == 8 ? 1 : -1));
      send_request(coef, idx, px, py);
   endtask

   initial begin : stimulus
      int unsigned qualities[6];
      qualities = '{37, 1, 100, 63, 127, 85};
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at reset quality: the centre gives a step of one, so
      // 136 lies exactly halfway between two multiples.
      send_request(16'sd136, 6'd0, 8'd128, 8'd128);
      send_request(-16'sd136, 6'd0, 8'd128, 8'd128);
      send_request(16'sd135, 6'd0, 8'd128, 8'd128);
      send_request(16'sh7FFF, 6'd63, 8'd0, 8'd255);
      send_request(16'sh8000, 6'd63, 8'd255, 8'd0);
      send_request(16'sd0, 6'd5, 8'd127, 8'd129);
      send_request(-16'sd1, 6'd40, 8'd1, 8'd128);
      send_request(16'sd1, 6'd63, 8'd128, 8'd1);
      drain_results();

      // Lowest quality, with every position bit set and clear.
      write_register(ADDR_QUALITY, 32'd1);
      send_request(16'sh7FFF, 6'd61, 8'd0, 8'd0);
      send_request(16'sh8000, 6'd61, 8'd255, 8'd255);
      send_request(16'sh4000, 6'd0, 8'd128, 8'd128);
      send_request(-16'sh4000, 6'd63, 8'd128, 8'd128);
      drain_results();

      // Quality zero acts as one; a write elsewhere in the map is ignored.
      write_register(ADDR_QUALITY, 32'd0);
      write_register(ADDR_UNUSED, 32'd77);
      send_request(16'sh7FFF, 6'd61, 8'd0, 8'd0);
      send_request(16'sd100, 6'd2, 8'd64, 8'd200);
      drain_results();

      // Above 100 acts as 100; the knee of the scale factor at quality 50.
      write_register(ADDR_QUALITY, 32'hFFFF_FFE5);
      send_request(16'sd5000, 6'd0, 8'd0, 8'd0);
      drain_results();
      write_register(ADDR_QUALITY, 32'd101);
      send_request(-16'sd5000, 6'd1, 8'd128, 8'd0);
      drain_results();
      write_register(ADDR_QUALITY, 32'd50);
      send_request(16'sd3000, 6'd9, 8'd0, 8'd0);
      send_request(16'sd3000, 6'd9, 8'd1, 8'd0);
      send_request(-16'sd3000, 6'd9, 8'd128, 8'd128);
      drain_results();

      // Random part, one quality per phase.
      for (int ph = 0; ph < 6; ph++) begin
         send_idle_pct = (ph < 2) ? 28 : (ph < 4) ? 72 : 0;
         recv_idle_pct = (ph < 2) ? 72 : (ph < 4) ? 28 : 0;
         write_register(ADDR_QUALITY, qualities[ph]);
         for (int n = 0; n < 240; n++) begin
            if (ph == 4 && n == 20) hold_request = 1'b1;
            if (ph == 2 && n == 120) begin
               req_tvalid <= 1'b0;
               @(posedge clock);
               while (quant_sb.pending.size() != 0) @(posedge clock);
            end
            send_random();
         end
         drain_results();
      end

      $display("Sent %0d requests, checked %0d results, %0d of them saturated.",
               sent_count, quant_sb.checked, quant_sb.saturations);
      $display("Covered quality clamping, unused register writes and long stalls.");
      if (quant_sb.errors == 0 && quant_sb.pending.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
